// ===== rtl/core/kehm_pkg.sv =====
package kehm_pkg;

    // Fixed field widths
    localparam int KEY_W   = 11;
    localparam int TIME_W  = 32;
    localparam int TAP_W   = 4;
    localparam int CFG_W   = 16;
    localparam int IDX_W   = 2;
    // Microsecond limits up to (65535 + 1) * 1000 fit in 26 bits
    localparam int LIM_W   = 26;

    localparam logic [LIM_W-1:0] US_PER_MS = LIM_W'(1000);

    // Register indexes
    localparam logic [IDX_W-1:0] REG_HOLD_MS        = 2'd0;
    localparam logic [IDX_W-1:0] REG_STREAK_PRESSES = 2'd1;
    localparam logic [IDX_W-1:0] REG_STREAK_GAP_MS  = 2'd2;

    // Register reset values, already scaled where the logic keeps microseconds
    localparam logic [LIM_W-1:0] HOLD_US_RST     = LIM_W'(1000 * 1000);
    localparam logic [TAP_W-1:0] STREAK_RST      = TAP_W'(3);
    localparam logic [LIM_W-1:0] GAP_LIMIT_RST   = LIM_W'((200 + 1) * 1000);
    localparam logic [TAP_W-1:0] TAP_MAX         = {TAP_W{1'b1}};

    // What one key lane reports for a word
    typedef struct packed {
        logic down;
        logic press;
        logic release_edge;
        logic hold;
    } lane_flags_t;

    // One result word
    typedef struct packed {
        logic [KEY_W-1:0] down_mask;
        logic [KEY_W-1:0] press_mask;
        logic [KEY_W-1:0] release_mask;
        logic [KEY_W-1:0] hold_mask;
        logic             streak_detected;
    } result_t;

endpackage

// ===== rtl/core/kehm_lane.sv =====
module kehm_lane
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_fire,
    input  logic                                level,
    input  logic [kehm_pkg::TIME_W-1:0]         now_us,
    input  logic [kehm_pkg::LIM_W-1:0]          hold_us,
    output kehm_pkg::lane_flags_t               flags
);

    logic                        prev_down_reg;
    logic [kehm_pkg::TIME_W-1:0] stamp_reg;
    logic                        down;
    logic                        press;
    logic [kehm_pkg::TIME_W-1:0] elapsed;
    logic                        held;

    // Derive edges and the hold test for this key
    always_comb
    begin
        down    = ~level;
        press   = down & ~prev_down_reg;
        elapsed = now_us - stamp_reg;
        if (press)
        begin
            held = (hold_us == '0);
        end
        else
        begin
            held = (elapsed >= {{(kehm_pkg::TIME_W-kehm_pkg::LIM_W){1'b0}}, hold_us});
        end
        flags.down         = down;
        flags.press        = press;
        flags.release_edge = prev_down_reg & ~down;
        flags.hold         = down & held;
    end

    // Track the previous level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_down_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            prev_down_reg <= down;
        end
    end

    // Stamp the press time
    always_ff @(posedge clk)
    begin
        if (in_fire && press)
        begin
            stamp_reg <= now_us;
        end
    end

endmodule

// ===== rtl/core/kehm_streak.sv =====
module kehm_streak
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_fire,
    input  logic                                menu_press,
    input  logic [kehm_pkg::TIME_W-1:0]         now_us,
    input  logic [kehm_pkg::TAP_W-1:0]          streak_presses,
    input  logic [kehm_pkg::LIM_W-1:0]          gap_limit,
    output logic                                fire
);

    logic [kehm_pkg::TAP_W-1:0]  tap_count_reg;
    logic [kehm_pkg::TAP_W-1:0]  tap_count_next;
    logic [kehm_pkg::TIME_W-1:0] last_tap_reg;
    logic [kehm_pkg::TIME_W-1:0] last_tap_next;
    logic [kehm_pkg::TAP_W-1:0]  bumped;
    logic [kehm_pkg::TIME_W-1:0] gap_us;
    logic                        too_long;

    // Count menu taps; a gap past the limit restarts or drops the streak
    always_comb
    begin
        gap_us   = now_us - last_tap_reg;
        too_long = (tap_count_reg != '0) &&
                   (gap_us >= {{(kehm_pkg::TIME_W-kehm_pkg::LIM_W){1'b0}}, gap_limit});
        tap_count_next = tap_count_reg;
        last_tap_next  = last_tap_reg;
        fire           = 1'b0;
        bumped         = tap_count_reg;
        if (menu_press)
        begin
            if (too_long)
            begin
                bumped = kehm_pkg::TAP_W'(1);
            end
            else if (tap_count_reg != kehm_pkg::TAP_MAX)
            begin
                bumped = tap_count_reg + kehm_pkg::TAP_W'(1);
            end
            last_tap_next = now_us;
            if (bumped >= streak_presses)
            begin
                tap_count_next = '0;
                fire           = 1'b1;
            end
            else
            begin
                tap_count_next = bumped;
            end
        end
        else if (too_long)
        begin
            tap_count_next = '0;
        end
    end

    // Hold the streak state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg <= '0;
            last_tap_reg  <= '0;
        end
        else if (in_fire)
        begin
            tap_count_reg <= tap_count_next;
            last_tap_reg  <= last_tap_next;
        end
    end

endmodule

// ===== rtl/core/kehm_merge.sv =====
module kehm_merge
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [kehm_pkg::KEY_W-1:0]          down_bits,
    input  logic [kehm_pkg::KEY_W-1:0]          press_bits,
    input  logic [kehm_pkg::KEY_W-1:0]          release_bits,
    input  logic [kehm_pkg::KEY_W-1:0]          hold_bits,
    input  logic                                streak_bit,
    output logic                                out_valid,
    input  logic                                out_ready,
    output kehm_pkg::result_t                   result
);

    kehm_pkg::result_t word;
    kehm_pkg::result_t out_reg;
    kehm_pkg::result_t skid_reg;
    logic              out_valid_reg;
    logic              skid_valid_reg;
    logic              in_fire;
    logic              out_fire;

    // Combine lane findings into one word
    always_comb
    begin
        word.down_mask       = down_bits;
        word.press_mask      = press_bits;
        word.release_mask    = release_bits;
        word.hold_mask       = hold_bits;
        word.streak_detected = streak_bit;
    end

    assign in_ready  = ~skid_valid_reg;
    assign in_fire   = in_valid & in_ready;
    assign out_fire  = out_valid_reg & out_ready;
    assign out_valid = out_valid_reg;
    assign result    = out_reg;

    // Advance the output register, park a word in the skid stage on a stall
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_fire || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= in_fire;
            end
            else
            begin
                out_valid_reg  <= in_fire;
            end
        end
        else if (in_fire)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Move payload alongside
    always_ff @(posedge clk)
    begin
        if (out_fire || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
                if (in_fire)
                begin
                    skid_reg <= word;
                end
            end
            else if (in_fire)
            begin
                out_reg <= word;
            end
        end
        else if (in_fire)
        begin
            skid_reg <= word;
        end
    end

endmodule

// ===== rtl/core/key_edge_hold_multitap_detector_top.sv =====
// Key edge, hold and multi-tap detector. Each input word is one key scan: active-low
// levels in key_levels (bit 0 is the menu key) and a wrapping microsecond stamp in
// now_us. One word is taken per clock while in_ready is high; its result is registered
// in an output register with a one-word skid stage, so the rate is one word per cycle
// until a stall fills the skid stage, set by each key lane and the menu streak counter.
// Keys at or above max(1, min(NUM_KEYS, 11)) are unscanned; every mask reads them as 0.
// Registers: 0 hold_ms, 1 streak_presses, 2 streak_gap_ms; write them only while
// the block is idle. A key's hold time counts from its press as seen by this block.
module key_edge_hold_multitap_detector_top
#(
    parameter int NUM_KEYS = 11
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [kehm_pkg::IDX_W-1:0]          cfg_index,
    input  logic [kehm_pkg::CFG_W-1:0]          cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [kehm_pkg::KEY_W-1:0]          key_levels,
    input  logic [kehm_pkg::TIME_W-1:0]         now_us,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [kehm_pkg::KEY_W-1:0]          down_mask,
    output logic [kehm_pkg::KEY_W-1:0]          press_mask,
    output logic [kehm_pkg::KEY_W-1:0]          release_mask,
    output logic [kehm_pkg::KEY_W-1:0]          hold_mask,
    output logic                                streak_detected
);

    localparam int LANES = (NUM_KEYS >= kehm_pkg::KEY_W) ? kehm_pkg::KEY_W :
                           ((NUM_KEYS < 1) ? 1 : NUM_KEYS);

    logic [kehm_pkg::LIM_W-1:0]  hold_us_reg;
    logic [kehm_pkg::TAP_W-1:0]  streak_presses_reg;
    logic [kehm_pkg::LIM_W-1:0]  gap_limit_reg;
    logic                        in_fire;
    logic [kehm_pkg::KEY_W-1:0]  down_bits;
    logic [kehm_pkg::KEY_W-1:0]  press_bits;
    logic [kehm_pkg::KEY_W-1:0]  release_bits;
    logic [kehm_pkg::KEY_W-1:0]  hold_bits;
    logic                        streak_bit;
    kehm_pkg::result_t           result;

    assign in_fire = in_valid & in_ready;

    // Take register writes, scaled to microseconds
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_us_reg        <= kehm_pkg::HOLD_US_RST;
            streak_presses_reg <= kehm_pkg::STREAK_RST;
            gap_limit_reg      <= kehm_pkg::GAP_LIMIT_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                kehm_pkg::REG_HOLD_MS:
                begin
                    hold_us_reg <= kehm_pkg::LIM_W'(cfg_data) * kehm_pkg::US_PER_MS;
                end
                kehm_pkg::REG_STREAK_PRESSES:
                begin
                    streak_presses_reg <= cfg_data[kehm_pkg::TAP_W-1:0];
                end
                kehm_pkg::REG_STREAK_GAP_MS:
                begin
                    gap_limit_reg <= (kehm_pkg::LIM_W'(cfg_data) + kehm_pkg::LIM_W'(1))
                                     * kehm_pkg::US_PER_MS;
                end
                default:
                begin
                end
            endcase
        end
    end

    // One lane per scanned key; unscanned bits stay zero
    for (genvar i = 0; i < kehm_pkg::KEY_W; i++)
    begin : g_lane
        if (i < LANES)
        begin : g_on
            kehm_pkg::lane_flags_t flags;

            kehm_lane u_lane
            (
                .clk     (clk),
                .rst_n   (rst_n),
                .in_fire (in_fire),
                .level   (key_levels[i]),
                .now_us  (now_us),
                .hold_us (hold_us_reg),
                .flags   (flags)
            );

            assign down_bits[i]    = flags.down;
            assign press_bits[i]   = flags.press;
            assign release_bits[i] = flags.release_edge;
            assign hold_bits[i]    = flags.hold;
        end
        else
        begin : g_off
            assign down_bits[i]    = 1'b0;
            assign press_bits[i]   = 1'b0;
            assign release_bits[i] = 1'b0;
            assign hold_bits[i]    = 1'b0;
        end
    end

    // Count menu key taps
    kehm_streak u_streak
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_fire        (in_fire),
        .menu_press     (press_bits[0]),
        .now_us         (now_us),
        .streak_presses (streak_presses_reg),
        .gap_limit      (gap_limit_reg),
        .fire           (streak_bit)
    );

    // Merge and buffer the result word
    kehm_merge u_merge
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .down_bits    (down_bits),
        .press_bits   (press_bits),
        .release_bits (release_bits),
        .hold_bits    (hold_bits),
        .streak_bit   (streak_bit),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result       (result)
    );

    assign down_mask       = result.down_mask;
    assign press_mask      = result.press_mask;
    assign release_mask    = result.release_mask;
    assign hold_mask       = result.hold_mask;
    assign streak_detected = result.streak_detected;

endmodule
